// ===== rtl/differential_incremental_pid_drive_defines.svh =====
// Assertion macros shared by the drive loop modules.
`ifndef DIFFERENTIAL_INCREMENTAL_PID_DRIVE_DEFINES_SVH
`define DIFFERENTIAL_INCREMENTAL_PID_DRIVE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DIPD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DIPD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/dipd_pkg.sv =====
package dipd_pkg;

	// Function codes of an input word.
	localparam logic FUNC_MEAS = 1'b0;
	localparam logic FUNC_CMD  = 1'b1;

	// Configuration register indexes.
	localparam int CFG_INDEX_W = 2;
	localparam logic [CFG_INDEX_W-1:0] CFG_KP         = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_KI         = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_KD         = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_HALF_TRACK = 2'd3;

	// Register reset values.
	localparam logic signed [15:0] KP_RESET         = 16'sd2048;
	localparam logic signed [15:0] KI_RESET         = 16'sd0;
	localparam logic signed [15:0] KD_RESET         = 16'sd2048;
	localparam logic        [15:0] HALF_TRACK_RESET = 16'd77;

	// Drive level limits, Q8.8.
	localparam logic [15:0] LEVEL_MAX   = 16'd25600;
	localparam logic [15:0] LEVEL_MIN   = 16'd6912;
	localparam logic [15:0] LEVEL_RESET = 16'd16256;

	// Side speed limits, 17 bit signed Q8.8.
	localparam logic signed [16:0] SPEED_MAX = 17'sd65535;
	localparam logic signed [16:0] SPEED_MIN = -17'sd65536;

	// Default depth of the queue between front and back.
	localparam int DIPD_QUEUE_DEPTH = 2;

	typedef struct packed {
		logic signed [15:0] kp;
		logic signed [15:0] ki;
		logic signed [15:0] kd;
		logic        [15:0] half_track;
	} cfg_t;

	typedef struct packed {
		logic               func;
		logic signed [15:0] linear_vel;
		logic signed [15:0] angular_vel;
	} in_word_t;

	typedef struct packed {
		logic [6:0] left_drive;
		logic [6:0] right_drive;
		logic       left_clamped;
		logic       right_clamped;
	} out_word_t;

	// A classified word: function and the two side speeds.
	typedef struct packed {
		logic               func;
		logic signed [16:0] left;
		logic signed [16:0] right;
	} cls_t;

endpackage

// ===== rtl/differential_incremental_pid_drive.sv =====
// Channel   Handshake              Payload
// in        in_valid / in_stall    in_data: func, linear_vel, angular_vel
// out       out_valid / out_stall  out_data: left/right drive, left/right clamp flag
// cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One word is taken every cycle while in_stall is low; a taken command passes the
// multiplier stage register, then the queue, then the controller update into the
// output register before it reaches out_valid.
// The controller updates both sides in the same cycle, which sets the one-word rate.
// Reset is asynchronous: gains and half track return to their defaults, speeds,
// integrals and errors to zero, and both drive levels to 63.5.
// A stalled output fills the queue; the input stalls only once the queue and the
// front stage are full. Measurements pass the back end even while the output waits.
module differential_incremental_pid_drive import dipd_pkg::*; #(
	parameter int QUEUE_DEPTH = DIPD_QUEUE_DEPTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  in_word_t               in_data,
	output logic                   out_valid,
	input  logic                   out_stall,
	output out_word_t              out_data,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [15:0]            cfg_data
);

	cfg_t cfg_q;
	logic push;
	cls_t push_data;
	logic full;
	logic pop;
	cls_t head;
	logic empty;

	// Configuration registers; every write is taken at once.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kp         <= KP_RESET;
			cfg_q.ki         <= KI_RESET;
			cfg_q.kd         <= KD_RESET;
			cfg_q.half_track <= HALF_TRACK_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_KP:         cfg_q.kp         <= cfg_data;
				CFG_KI:         cfg_q.ki         <= cfg_data;
				CFG_KD:         cfg_q.kd         <= cfg_data;
				CFG_HALF_TRACK: cfg_q.half_track <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	dipd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	dipd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.head      (head),
		.empty     (empty)
	);

	dipd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.head      (head),
		.empty     (empty),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

// ===== rtl/dipd_front.sv =====
module dipd_front import dipd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_t     cfg,
	input  logic     in_valid,
	output logic     in_stall,
	input  in_word_t in_data,
	output logic     push,
	output cls_t     push_data,
	input  logic     full
);

	logic               valid_s1;
	logic               func_s1;
	logic signed [15:0] lin_s1;
	logic signed [32:0] prod_s1;
	logic               accept;
	logic signed [24:0] term;
	logic signed [25:0] lin_ext;
	logic signed [25:0] sum_l;
	logic signed [25:0] sum_r;

	// The stage holds while its word cannot enter the queue.
	assign in_stall = valid_s1 && full;
	assign accept   = in_valid && !in_stall;
	assign push     = valid_s1 && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	// Half track times yaw rate, registered before the side sums.
	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1 <= in_data.func;
			lin_s1  <= in_data.linear_vel;
			prod_s1 <= $signed({1'b0, cfg.half_track}) * in_data.angular_vel;
		end
	end

	// Side speeds, floor shifted to Q8.8 and saturated to 17 bits.
	always_comb begin
		term    = prod_s1[32:8];
		lin_ext = 26'(lin_s1);
		sum_l   = lin_ext - 26'(term);
		sum_r   = lin_ext + 26'(term);

		push_data.func = func_s1;
		if (sum_l > 26'(SPEED_MAX)) begin
			push_data.left = SPEED_MAX;
		end else if (sum_l < 26'(SPEED_MIN)) begin
			push_data.left = SPEED_MIN;
		end else begin
			push_data.left = sum_l[16:0];
		end
		if (sum_r > 26'(SPEED_MAX)) begin
			push_data.right = SPEED_MAX;
		end else if (sum_r < 26'(SPEED_MIN)) begin
			push_data.right = SPEED_MIN;
		end else begin
			push_data.right = sum_r[16:0];
		end
	end

endmodule

// ===== rtl/dipd_queue.sv =====
module dipd_queue import dipd_pkg::*; #(
	parameter int DEPTH = DIPD_QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cls_t push_data,
	output logic full,
	input  logic pop,
	output cls_t head,
	output logic empty
);

	`include "differential_incremental_pid_drive_defines.svh"

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cls_t             entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = entry_q[rd_ptr_q];

	// Pointers wrap at the depth, which need not be a power of two.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	`DIPD_ASSERT_IMPL(a_no_push_full, clk, arst_n, push, !full, "push into a full queue")
	`DIPD_ASSERT_IMPL(a_no_pop_empty, clk, arst_n, pop, !empty, "pop from an empty queue")
	`DIPD_ASSERT_NEXT(a_count_up, clk, arst_n, push && !pop, count_q == $past(count_q) + 1'b1, "queue count did not rise on push")

endmodule

// ===== rtl/dipd_back.sv =====
module dipd_back import dipd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  cls_t      head,
	input  logic      empty,
	output logic      pop,
	output logic      out_valid,
	input  logic      out_stall,
	output out_word_t out_data
);

	`include "differential_incremental_pid_drive_defines.svh"

	logic signed [16:0] meas_q  [2];
	logic signed [31:0] integ_q [2];
	logic signed [17:0] prev_q  [2];
	logic        [15:0] level_q [2];
	logic               out_valid_q;
	out_word_t          out_q;

	logic signed [16:0] desired   [2];
	logic signed [17:0] err       [2];
	logic signed [18:0] diff      [2];
	logic signed [32:0] integ_sum [2];
	logic signed [31:0] integ_new [2];
	logic signed [33:0] prod_p    [2];
	logic signed [47:0] prod_i    [2];
	logic signed [34:0] prod_d    [2];
	logic signed [49:0] corr      [2];
	logic signed [37:0] step      [2];
	logic signed [38:0] lvl_sum   [2];
	logic        [15:0] level_new [2];
	logic               clamp     [2];
	logic               is_cmd;

	// A command needs the output register; a measurement never does.
	assign is_cmd    = (head.func == FUNC_CMD);
	assign pop       = !empty && (!is_cmd || !out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Per-side error, integral, difference, correction and clamp.
	always_comb begin
		desired[0] = head.left;
		desired[1] = head.right;
		for (int s = 0; s < 2; s++) begin
			err[s]       = 18'(desired[s]) - 18'(meas_q[s]);
			diff[s]      = 19'(err[s]) - 19'(prev_q[s]);
			integ_sum[s] = 33'(integ_q[s]) + 33'(err[s]);
			if (integ_sum[s][32] != integ_sum[s][31]) begin
				integ_new[s] = integ_sum[s][32] ? {1'b1, 31'b0} : {1'b0, {31{1'b1}}};
			end else begin
				integ_new[s] = integ_sum[s][31:0];
			end
			prod_p[s]  = cfg.kp * err[s];
			prod_i[s]  = cfg.ki * integ_new[s];
			prod_d[s]  = cfg.kd * diff[s];
			corr[s]    = 50'(prod_p[s]) + 50'(prod_i[s]) + 50'(prod_d[s]);
			step[s]    = corr[s][49:12];
			lvl_sum[s] = $signed({23'b0, level_q[s]}) + 39'(step[s]);
			if (lvl_sum[s] > $signed({23'b0, LEVEL_MAX})) begin
				level_new[s] = LEVEL_MAX;
				clamp[s]     = 1'b1;
			end else if (lvl_sum[s] < $signed({23'b0, LEVEL_MIN})) begin
				level_new[s] = LEVEL_MIN;
				clamp[s]     = 1'b1;
			end else begin
				level_new[s] = lvl_sum[s][15:0];
				clamp[s]     = 1'b0;
			end
		end
	end

	// Loop state: measurements store speeds, commands advance the controller.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < 2; s++) begin
				meas_q[s]  <= '0;
				integ_q[s] <= '0;
				prev_q[s]  <= '0;
				level_q[s] <= LEVEL_RESET;
			end
		end else if (pop) begin
			if (is_cmd) begin
				for (int s = 0; s < 2; s++) begin
					integ_q[s] <= integ_new[s];
					prev_q[s]  <= err[s];
					level_q[s] <= level_new[s];
				end
			end else begin
				meas_q[0] <= head.left;
				meas_q[1] <= head.right;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && is_cmd) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && is_cmd) begin
			out_q.left_drive    <= level_new[0][14:8];
			out_q.right_drive   <= level_new[1][14:8];
			out_q.left_clamped  <= clamp[0];
			out_q.right_clamped <= clamp[1];
		end
	end

	`DIPD_ASSERT_IMPL(a_level_range, clk, arst_n, 1'b1, level_q[0] >= LEVEL_MIN && level_q[0] <= LEVEL_MAX && level_q[1] >= LEVEL_MIN && level_q[1] <= LEVEL_MAX, "drive level left its limits")
	`DIPD_ASSERT_NEXT(a_meas_keeps_level, clk, arst_n, pop && !is_cmd, $stable(level_q[0]) && $stable(level_q[1]), "measurement changed a drive level")
	`DIPD_ASSERT_IMPL(a_clamp_at_limit, clk, arst_n, out_valid_q && out_q.left_clamped, out_q.left_drive == 7'd27 || out_q.left_drive == 7'd100, "clamp flag without a limit value")

endmodule
